FILE: rtl/stack_with_positional_insert_top_assert.svh
// Assertion macros shared by the stack checker.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef STACK_WITH_POSITIONAL_INSERT_TOP_ASSERT_SVH
`define STACK_WITH_POSITIONAL_INSERT_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define SWPI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stack checker: property violated");

// Signal that must never be high outside reset
`define SWPI_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("stack checker: forbidden condition seen");

`endif

FILE: rtl/swpi_pkg.sv
// Shared types and constants for the positional-insert stack.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swpi_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int WORD_WIDTH  = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int POS_W       = 6;
  localparam int FILL_W      = 6;
  localparam int STAT_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Broadcast from the decoder to every cell
  typedef struct packed {
    logic             wr_en;   // a word is written this cycle
    logic             ins;     // entries at and above slot move up
    logic [IDX_W-1:0] slot;    // cell that takes the new word
    logic [CNT_W-1:0] count;   // fill level before the operation
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/swpi_cell.sv
// One storage cell of the stack: holds, loads the new word, or takes its lower neighbor.
// Depends on swpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpi_cell (
  input  wire logic                             clk,
  input  wire logic [swpi_pkg::IDX_W-1:0]       idx,
  input  wire swpi_pkg::cell_ctrl_t             ctrl,
  input  wire logic [swpi_pkg::WORD_WIDTH-1:0]  new_word,
  input  wire logic [swpi_pkg::WORD_WIDTH-1:0]  lower_word,
  output logic      [swpi_pkg::WORD_WIDTH-1:0]  word
);

  logic load;
  logic shift;

  // Cell role for this cycle
  assign load  = ctrl.wr_en && (idx == ctrl.slot);
  assign shift = ctrl.wr_en && ctrl.ins && (idx > ctrl.slot) &&
                 (swpi_pkg::CNT_W'(idx) <= ctrl.count);

  // Payload only, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      word <= new_word;
    end else if (shift) begin
      word <= lower_word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swpi_ctrl.sv
// Operation decoder: checks limits, picks the target cell and the next fill level.
// Depends on swpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swpi_ctrl (
  input  wire logic [swpi_pkg::OP_W-1:0]  operation,
  input  wire logic [swpi_pkg::POS_W-1:0] position,
  input  wire logic [swpi_pkg::CNT_W-1:0] count,
  output swpi_pkg::cell_ctrl_t            ctrl,
  output swpi_pkg::status_t               status,
  output logic                            pop_ok,
  output logic [swpi_pkg::CNT_W-1:0]      count_next
);

  logic empty;
  logic full;
  logic pos_ok;

  assign empty  = (count == '0);
  assign full   = (count == swpi_pkg::CNT_W'(swpi_pkg::STACK_DEPTH));
  assign pos_ok = (position != '0) &&
                  (swpi_pkg::CNT_W'(position) <= count) &&
                  (swpi_pkg::POS_W'(count) >= position);

  // Decode one transaction
  always_comb begin
    ctrl.wr_en = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.slot  = count[swpi_pkg::IDX_W-1:0];
    ctrl.count = count;
    status     = swpi_pkg::ST_OK;
    pop_ok     = 1'b0;
    count_next = count;
    unique case (operation)
      swpi_pkg::OP_PUSH: begin
        if (full) begin
          status = swpi_pkg::ST_FULL;
        end else begin
          ctrl.wr_en = 1'b1;
          count_next = count + 1'b1;
        end
      end
      swpi_pkg::OP_POP: begin
        if (empty) begin
          status = swpi_pkg::ST_EMPTY;
        end else begin
          pop_ok     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      swpi_pkg::OP_INSERT: begin
        priority if (empty) begin
          status = swpi_pkg::ST_EMPTY;
        end else if (full) begin
          status = swpi_pkg::ST_FULL;
        end else if (!pos_ok) begin
          status = swpi_pkg::ST_BADPOS;
        end else begin
          ctrl.wr_en = 1'b1;
          ctrl.ins   = 1'b1;
          ctrl.slot  = swpi_pkg::IDX_W'(position - 1'b1);
          count_next = count + 1'b1;
        end
      end
      default: begin
        // unused code: no operation
        status = swpi_pkg::ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/stack_with_positional_insert_top.sv
// Top level of the positional-insert stack: decoder, row of cells, result registers.
// Depends on swpi_pkg, swpi_ctrl and swpi_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  command  | start / busy         | operation, value, position
//  result   | done (one-cycle)     | popped_value, status, fill_count
//
// A transaction is taken at any edge with start high; busy stays low.
// Each cell holds, loads or takes its lower neighbor at the same edge, and the
// result is registered and shows in the next cycle.
// Reset clears the fill level and the result strobe; cell contents are not reset.
// The result has no back-pressure and is valid only while done is high.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_positional_insert_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [swpi_pkg::OP_W-1:0]      operation,
  input  wire logic signed [swpi_pkg::VAL_W-1:0] value,
  input  wire logic [swpi_pkg::POS_W-1:0]     position,
  output logic                                done,
  output logic signed [swpi_pkg::VAL_W-1:0]   popped_value,
  output logic [swpi_pkg::STAT_W-1:0]         status,
  output logic [swpi_pkg::FILL_W-1:0]         fill_count
);

  logic [swpi_pkg::CNT_W-1:0]      count;
  logic [swpi_pkg::CNT_W-1:0]      count_next;
  swpi_pkg::cell_ctrl_t            ctrl;
  swpi_pkg::status_t               st;
  logic                            pop_ok;
  logic [swpi_pkg::WORD_WIDTH-1:0] new_word;
  logic [swpi_pkg::WORD_WIDTH-1:0] cells [swpi_pkg::STACK_DEPTH];
  logic [swpi_pkg::WORD_WIDTH-1:0] top_word;
  swpi_pkg::cell_ctrl_t            cell_ctrl;

  assign busy     = 1'b0;
  assign new_word = swpi_pkg::WORD_WIDTH'(value);

  swpi_ctrl u_ctrl (
    .operation  (operation),
    .position   (position),
    .count      (count),
    .ctrl       (ctrl),
    .status     (st),
    .pop_ok     (pop_ok),
    .count_next (count_next)
  );

  // Writes only on an accepted transaction
  always_comb begin
    cell_ctrl       = ctrl;
    cell_ctrl.wr_en = ctrl.wr_en && start;
  end

  // Row of cells, index 0 is the bottom entry
  for (genvar i = 0; i < swpi_pkg::STACK_DEPTH; i++) begin : g_cell
    logic [swpi_pkg::WORD_WIDTH-1:0] lower;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_upper
      assign lower = cells[i-1];
    end
    swpi_cell u_cell (
      .clk        (clk),
      .idx        (swpi_pkg::IDX_W'(i)),
      .ctrl       (cell_ctrl),
      .new_word   (new_word),
      .lower_word (lower),
      .word       (cells[i])
    );
  end

  // Current top entry for pop
  assign top_word = cells[swpi_pkg::IDX_W'(count - 1'b1)];

  // Fill level and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (start) begin
      popped_value <= pop_ok ? swpi_pkg::VAL_W'($signed(top_word)) : '0;
      status       <= st;
      fill_count   <= swpi_pkg::FILL_W'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/swpi_checker.sv
// Port-level checker for the positional-insert stack, bound to the top level.
// Depends on swpi_pkg and stack_with_positional_insert_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_with_positional_insert_top_assert.svh"

module swpi_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [swpi_pkg::OP_W-1:0]         operation,
  input wire logic signed [swpi_pkg::VAL_W-1:0] value,
  input wire logic [swpi_pkg::POS_W-1:0]        position,
  input wire logic                              done,
  input wire logic signed [swpi_pkg::VAL_W-1:0] popped_value,
  input wire logic [swpi_pkg::STAT_W-1:0]       status,
  input wire logic [swpi_pkg::FILL_W-1:0]       fill_count
);

  // Each accepted transaction gives a result in the next cycle
  `SWPI_ASSERT(a_result_follows, (start && !busy) |=> done)
  // No result without a transaction before it
  `SWPI_ASSERT(a_no_spurious, done |-> $past(start && !busy))
  // A failed operation never returns a word
  `SWPI_ASSERT(a_err_zero, (done && status != swpi_pkg::ST_OK) |-> (popped_value == '0))
  // Full status means the stack really is at capacity
  `SWPI_ASSERT(a_full_level,
               (done && status == swpi_pkg::ST_FULL) |->
               (fill_count == swpi_pkg::FILL_W'(swpi_pkg::STACK_DEPTH)))
  // Fill level never passes the depth
  `SWPI_NEVER(a_overfill, done && (fill_count > swpi_pkg::FILL_W'(swpi_pkg::STACK_DEPTH)))

endmodule

bind stack_with_positional_insert_top swpi_checker u_swpi_checker (.*);

`default_nettype wire
